/* rtl/tccs_pkg.sv */
`timescale 1ns / 1ps

package tccs_pkg;

   // Screen geometry defaults.
   localparam int COLUMNS_DEF = 80;
   localparam int ROWS_DEF    = 25;

   // Field widths of the two channels and of the colour registers.
   localparam int MODE_W   = 2;
   localparam int CHAR_W   = 8;
   localparam int COL_W    = 7;
   localparam int ROW_W    = 5;
   localparam int LIN_W    = 11;
   localparam int ATTR_W   = 8;
   localparam int COLOR_W  = 4;

   // Configuration port.
   localparam int CSR_AW = 3;
   localparam int CSR_DW = 32;
   localparam logic REG_FOREGROUND = 1'b0;
   localparam logic REG_BACKGROUND = 1'b1;
   localparam logic [COLOR_W-1:0] FOREGROUND_RESET = 4'd7;
   localparam logic [COLOR_W-1:0] BACKGROUND_RESET = 4'd0;

   // Control characters and the blank cell.
   localparam logic [CHAR_W-1:0] CHAR_LF    = 8'd10;
   localparam logic [CHAR_W-1:0] CHAR_CR    = 8'd13;
   localparam logic [CHAR_W-1:0] CHAR_TAB   = 8'd9;
   localparam logic [CHAR_W-1:0] CHAR_BS    = 8'd8;
   localparam logic [CHAR_W-1:0] CHAR_SPACE = 8'h20;
   localparam int TAB_STEP = 8;
   localparam logic [ATTR_W-1:0] RESET_ATTR = 8'h07;

   typedef enum logic [MODE_W-1:0] {
      MODE_PUT   = 2'd0,
      MODE_READ  = 2'd1,
      MODE_CLEAR = 2'd2,
      MODE_SET   = 2'd3
   } mode_type;

   typedef enum logic [2:0] {
      ST_FILL,
      ST_IDLE,
      ST_READ,
      ST_COPY,
      ST_BLANK
   } state_type;

endpackage

/* rtl/tccs_req_if.sv */
`timescale 1ns / 1ps

interface tccs_req_if;
   logic                             valid;
   logic                             ready;
   logic [tccs_pkg::MODE_W-1:0]      mode;
   logic [tccs_pkg::CHAR_W-1:0]      char_code;
   logic [tccs_pkg::COL_W-1:0]       column;
   logic [tccs_pkg::ROW_W-1:0]       row;

   modport source (output valid, mode, char_code, column, row, input ready);
   modport sink   (input valid, mode, char_code, column, row, output ready);
endinterface

/* rtl/tccs_rsp_if.sv */
`timescale 1ns / 1ps

interface tccs_rsp_if;
   logic                             valid;
   logic                             ready;
   logic [tccs_pkg::COL_W-1:0]       cursor_col;
   logic [tccs_pkg::ROW_W-1:0]       cursor_row;
   logic [tccs_pkg::LIN_W-1:0]       cursor_linear;
   logic [tccs_pkg::CHAR_W-1:0]      cell_char;
   logic [tccs_pkg::ATTR_W-1:0]      cell_attr;

   modport source (output valid, cursor_col, cursor_row, cursor_linear, cell_char, cell_attr,
                   input ready);
   modport sink   (input valid, cursor_col, cursor_row, cursor_linear, cell_char, cell_attr,
                   output ready);
endinterface

/* rtl/text_console_cursor_scroll.sv */
`timescale 1ns / 1ps

// Channel    | Direction | Handshake          | Payload
// req_chan   | in        | valid / ready      | mode, char_code, column, row
// rsp_chan   | out       | valid / ready      | cursor_col, cursor_row, cursor_linear,
//            |           |                    | cell_char, cell_attr
// csr_*      | in        | psel/penable/pready| foreground (0x0), background (0x4)
//
// Put without scroll and set cursor finish in the accepting cycle; read cell passes through ST_READ
// because of the registered read port of the frame memory.
// A scroll and a clear are bounded by the single write port of the frame memory (one
// cell per cycle). After reset a clearing pass writes every cell blank; no transaction
// is accepted meanwhile, register writes are.
// One item is in flight at a time; a new item is taken when the result register is free or
// is being emptied in the same cycle.

module text_console_cursor_scroll #(
   parameter int COLUMNS = tccs_pkg::COLUMNS_DEF,
   parameter int ROWS    = tccs_pkg::ROWS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   tccs_req_if.sink                      req_chan,
   tccs_rsp_if.source                    rsp_chan,
   input  logic                          csr_psel,
   input  logic                          csr_penable,
   input  logic                          csr_pwrite,
   input  logic [tccs_pkg::CSR_AW-1:0]   csr_paddr,
   input  logic [tccs_pkg::CSR_DW-1:0]   csr_pwdata,
   output logic [tccs_pkg::CSR_DW-1:0]   csr_prdata,
   output logic                          csr_pready
);

   localparam int CELLS     = COLUMNS * ROWS;
   localparam int AW        = $clog2(CELLS);
   localparam int CW        = $clog2(COLUMNS);
   localparam int RW        = $clog2(ROWS);
   localparam int EW        = tccs_pkg::CHAR_W + tccs_pkg::ATTR_W;
   localparam logic [AW-1:0] LAST_CELL = AW'(CELLS - 1);
   localparam logic [AW-1:0] LAST_COPY = AW'(CELLS - COLUMNS - 1);
   localparam logic [AW-1:0] FIRST_LAST_ROW = AW'(CELLS - COLUMNS);

   function automatic logic [AW-1:0] lin_addr(input logic [RW-1:0] r, input logic [CW-1:0] c);
      return AW'(int'(r) * COLUMNS + int'(c));
   endfunction

   // Configuration registers.
   logic [tccs_pkg::COLOR_W-1:0] fg_ff, bg_ff;
   logic                         csr_wr;
   logic [tccs_pkg::ATTR_W-1:0]  attr;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign attr       = {bg_ff, fg_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         fg_ff <= tccs_pkg::FOREGROUND_RESET;
         bg_ff <= tccs_pkg::BACKGROUND_RESET;
      end else if (csr_wr) begin
         if (csr_paddr[2] == tccs_pkg::REG_FOREGROUND) begin
            fg_ff <= csr_pwdata[tccs_pkg::COLOR_W-1:0];
         end else begin
            bg_ff <= csr_pwdata[tccs_pkg::COLOR_W-1:0];
         end
      end
   end

   always_comb begin
      if (csr_paddr[2] == tccs_pkg::REG_FOREGROUND) begin
         csr_prdata = tccs_pkg::CSR_DW'(fg_ff);
      end else begin
         csr_prdata = tccs_pkg::CSR_DW'(bg_ff);
      end
   end

   // Frame memory.
   logic [EW-1:0] frame_ff [CELLS];
   logic [EW-1:0] mem_rd_ff;
   logic          mem_we;
   logic [AW-1:0] mem_waddr, mem_raddr;
   logic [EW-1:0] mem_wdata;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         frame_ff[mem_waddr] <= mem_wdata;
      end
      mem_rd_ff <= frame_ff[mem_raddr];
   end

   // Control and cursor state.
   tccs_pkg::state_type state_ff, state_in;
   logic [CW-1:0] cur_col_ff, cur_col_in;
   logic [RW-1:0] cur_row_ff, cur_row_in;
   logic [AW-1:0] cnt_ff, cnt_in;
   logic          pend_ff, pend_in;
   logic [AW-1:0] dst_ff, dst_in;
   logic [EW-1:0] fill_ff, fill_in;
   logic          fill_cmd_ff, fill_cmd_in;

   logic                          rsp_valid_ff, rsp_load;
   logic [tccs_pkg::COL_W-1:0]    rsp_col_ff;
   logic [tccs_pkg::ROW_W-1:0]    rsp_row_ff;
   logic [tccs_pkg::LIN_W-1:0]    rsp_lin_ff;
   logic [tccs_pkg::CHAR_W-1:0]   rsp_char_ff, rsp_char_in;
   logic [tccs_pkg::ATTR_W-1:0]   rsp_attr_ff, rsp_attr_in;

   logic                req_accept;
   tccs_pkg::mode_type  req_mode;

   assign req_chan.ready = (state_ff == tccs_pkg::ST_IDLE) && (!rsp_valid_ff || rsp_chan.ready);
   assign req_accept     = req_chan.valid && req_chan.ready;
   assign req_mode       = tccs_pkg::mode_type'(req_chan.mode);

   // Clamped coordinates for read cell and set cursor.
   logic [CW-1:0] clamp_col;
   logic [RW-1:0] clamp_row;

   always_comb begin
      if (int'(req_chan.column) > COLUMNS - 1) begin
         clamp_col = CW'(COLUMNS - 1);
      end else begin
         clamp_col = CW'(req_chan.column);
      end
      if (int'(req_chan.row) > ROWS - 1) begin
         clamp_row = RW'(ROWS - 1);
      end else begin
         clamp_row = RW'(req_chan.row);
      end
   end

   // Cursor movement of a put.
   logic [CW:0]   put_col_ext;
   logic [RW:0]   put_row_ext;
   logic          put_wr, put_scroll;
   logic [CW-1:0] put_col;
   logic [RW-1:0] put_row;

   always_comb begin
      put_col_ext = {1'b0, cur_col_ff};
      put_row_ext = {1'b0, cur_row_ff};
      put_wr      = 1'b0;
      unique case (req_chan.char_code)
         tccs_pkg::CHAR_LF: begin
            put_col_ext = '0;
            put_row_ext = put_row_ext + (RW+1)'(1);
         end
         tccs_pkg::CHAR_CR: begin
            put_col_ext = '0;
         end
         tccs_pkg::CHAR_TAB: begin
            put_col_ext = (put_col_ext + (CW+1)'(tccs_pkg::TAB_STEP))
                          & ~(CW+1)'(tccs_pkg::TAB_STEP - 1);
         end
         tccs_pkg::CHAR_BS: begin
            if (cur_col_ff != '0) begin
               put_col_ext = put_col_ext - (CW+1)'(1);
            end
         end
         default: begin
            put_wr      = 1'b1;
            put_col_ext = put_col_ext + (CW+1)'(1);
         end
      endcase
      if (int'(put_col_ext) >= COLUMNS) begin
         put_col_ext = '0;
         put_row_ext = put_row_ext + (RW+1)'(1);
      end
      put_scroll = int'(put_row_ext) >= ROWS;
      put_col    = put_col_ext[CW-1:0];
      put_row    = put_scroll ? RW'(ROWS - 1) : put_row_ext[RW-1:0];
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         tccs_pkg::ST_IDLE: begin
            if (req_accept) begin
               unique case (req_mode)
                  tccs_pkg::MODE_PUT: begin
                     state_in = put_scroll ? tccs_pkg::ST_COPY : tccs_pkg::ST_IDLE;
                  end
                  tccs_pkg::MODE_READ:  state_in = tccs_pkg::ST_READ;
                  tccs_pkg::MODE_CLEAR: state_in = tccs_pkg::ST_FILL;
                  tccs_pkg::MODE_SET:   state_in = tccs_pkg::ST_IDLE;
               endcase
            end
         end
         tccs_pkg::ST_READ: state_in = tccs_pkg::ST_IDLE;
         tccs_pkg::ST_COPY: begin
            if (cnt_ff == LAST_COPY) begin
               state_in = tccs_pkg::ST_BLANK;
            end
         end
         tccs_pkg::ST_BLANK: begin
            if (!pend_ff && cnt_ff == LAST_CELL) begin
               state_in = tccs_pkg::ST_IDLE;
            end
         end
         tccs_pkg::ST_FILL: begin
            if (cnt_ff == LAST_CELL) begin
               state_in = tccs_pkg::ST_IDLE;
            end
         end
         default: state_in = tccs_pkg::ST_IDLE;
      endcase
   end

   // Datapath and memory control.
   always_comb begin
      cur_col_in  = cur_col_ff;
      cur_row_in  = cur_row_ff;
      cnt_in      = cnt_ff;
      pend_in     = pend_ff;
      dst_in      = dst_ff;
      fill_in     = fill_ff;
      fill_cmd_in = fill_cmd_ff;
      mem_we      = 1'b0;
      mem_waddr   = lin_addr(cur_row_ff, cur_col_ff);
      mem_wdata   = {attr, req_chan.char_code};
      mem_raddr   = lin_addr(clamp_row, clamp_col);
      rsp_load    = 1'b0;
      rsp_char_in = '0;
      rsp_attr_in = '0;
      unique case (state_ff)
         tccs_pkg::ST_IDLE: begin
            if (req_accept) begin
               unique case (req_mode)
                  tccs_pkg::MODE_PUT: begin
                     mem_we     = put_wr;
                     cur_col_in = put_col;
                     cur_row_in = put_row;
                     fill_in    = {attr, tccs_pkg::CHAR_SPACE};
                     cnt_in     = '0;
                     pend_in    = 1'b0;
                     rsp_load   = !put_scroll;
                  end
                  tccs_pkg::MODE_READ: begin
                  end
                  tccs_pkg::MODE_CLEAR: begin
                     cur_col_in  = '0;
                     cur_row_in  = '0;
                     fill_in     = {attr, tccs_pkg::CHAR_SPACE};
                     fill_cmd_in = 1'b1;
                     cnt_in      = '0;
                  end
                  tccs_pkg::MODE_SET: begin
                     cur_col_in = clamp_col;
                     cur_row_in = clamp_row;
                     rsp_load   = 1'b1;
                  end
               endcase
            end
         end
         tccs_pkg::ST_READ: begin
            rsp_load    = 1'b1;
            rsp_char_in = mem_rd_ff[tccs_pkg::CHAR_W-1:0];
            rsp_attr_in = mem_rd_ff[EW-1:tccs_pkg::CHAR_W];
         end
         tccs_pkg::ST_COPY: begin
            // Reads run one row ahead of the writes, so the two never touch the same cell.
            mem_raddr = cnt_ff + AW'(COLUMNS);
            mem_we    = pend_ff;
            mem_waddr = dst_ff;
            mem_wdata = mem_rd_ff;
            pend_in   = 1'b1;
            dst_in    = cnt_ff;
            cnt_in    = (cnt_ff == LAST_COPY) ? FIRST_LAST_ROW : cnt_ff + AW'(1);
         end
         tccs_pkg::ST_BLANK: begin
            mem_we = 1'b1;
            if (pend_ff) begin
               // The last copied entry goes out before the bottom row is blanked.
               mem_waddr = dst_ff;
               mem_wdata = mem_rd_ff;
               pend_in   = 1'b0;
            end else begin
               mem_waddr = cnt_ff;
               mem_wdata = fill_ff;
               if (cnt_ff == LAST_CELL) begin
                  rsp_load = 1'b1;
               end else begin
                  cnt_in = cnt_ff + AW'(1);
               end
            end
         end
         tccs_pkg::ST_FILL: begin
            mem_we    = 1'b1;
            mem_waddr = cnt_ff;
            mem_wdata = fill_ff;
            if (cnt_ff == LAST_CELL) begin
               rsp_load    = fill_cmd_ff;
               fill_cmd_in = 1'b0;
            end else begin
               cnt_in = cnt_ff + AW'(1);
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= tccs_pkg::ST_FILL;
         cur_col_ff   <= '0;
         cur_row_ff   <= '0;
         cnt_ff       <= '0;
         pend_ff      <= 1'b0;
         fill_ff      <= {tccs_pkg::RESET_ATTR, tccs_pkg::CHAR_SPACE};
         fill_cmd_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         cur_col_ff  <= cur_col_in;
         cur_row_ff  <= cur_row_in;
         cnt_ff      <= cnt_in;
         pend_ff     <= pend_in;
         fill_ff     <= fill_in;
         fill_cmd_ff <= fill_cmd_in;
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      dst_ff <= dst_in;
      if (rsp_load) begin
         rsp_col_ff  <= tccs_pkg::COL_W'(cur_col_in);
         rsp_row_ff  <= tccs_pkg::ROW_W'(cur_row_in);
         rsp_lin_ff  <= tccs_pkg::LIN_W'(lin_addr(cur_row_in, cur_col_in));
         rsp_char_ff <= rsp_char_in;
         rsp_attr_ff <= rsp_attr_in;
      end
   end

   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.cursor_col    = rsp_col_ff;
   assign rsp_chan.cursor_row    = rsp_row_ff;
   assign rsp_chan.cursor_linear = rsp_lin_ff;
   assign rsp_chan.cell_char     = rsp_char_ff;
   assign rsp_chan.cell_attr     = rsp_attr_ff;

`ifndef NO_ASSERTIONS
   // A finished result must never land on one that is still waiting.
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      rsp_load |-> (!rsp_valid_ff || rsp_chan.ready))
      else $error("result register overwritten");

   // The cursor stays on the screen.
   a_cursor_range: assert property (@(posedge clock) disable iff (reset)
      (int'(cur_col_ff) < COLUMNS) && (int'(cur_row_ff) < ROWS))
      else $error("cursor off screen");

   // A read cell transaction answers in the following cycle.
   a_read_latency: assert property (@(posedge clock) disable iff (reset)
      (req_accept && req_mode == tccs_pkg::MODE_READ) |=> rsp_load)
      else $error("read cell result late");
`endif

endmodule
